FILE: hw/rtl/cssc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cssc_pkg;

    localparam int KindWidth = 3;
    localparam int CfgIndexWidth = 2;
    localparam int CfgDataWidth = 8;
    localparam int InDataWidth = 24;
    localparam int OutDataWidth = 32;

    localparam logic [KindWidth-1:0] KIND_PULSE    = 3'd0;
    localparam logic [KindWidth-1:0] KIND_SCAN     = 3'd1;
    localparam logic [KindWidth-1:0] KIND_CLEAR    = 3'd2;
    localparam logic [KindWidth-1:0] KIND_INC_SEC  = 3'd3;
    localparam logic [KindWidth-1:0] KIND_INC_MIN  = 3'd4;
    localparam logic [KindWidth-1:0] KIND_INC_HOUR = 3'd5;
    localparam logic [KindWidth-1:0] KIND_LOAD     = 3'd6;

    localparam logic [CfgIndexWidth-1:0] REG_RUN_ENABLE       = 2'd0;
    localparam logic [CfgIndexWidth-1:0] REG_SHOW_MIN_SEC     = 2'd1;
    localparam logic [CfgIndexWidth-1:0] REG_DISPLAY_ENABLE   = 2'd2;
    localparam logic [CfgIndexWidth-1:0] REG_TICKS_PER_SECOND = 2'd3;

    localparam logic [5:0] MAX_UNIT = 6'd59;
    localparam logic [4:0] MAX_HOUR = 5'd23;
    localparam logic [7:0] SEG_BLANK = 8'd255;
    localparam logic [7:0] DOT_MASK = 8'h7F;
    localparam logic [1:0] SLOT_LEFT = 2'd3;
    localparam logic [7:0] TICKS_RESET = 8'd2;

    typedef struct packed {
        logic [3:0] tens;
        logic [3:0] units;
    } digit_pair_t;

    // active-low pattern for one decimal digit
    function automatic logic [7:0] seg_of(input logic [3:0] digit);
        logic [7:0] pattern;
        case (digit)
            4'd0: pattern = 8'd192;
            4'd1: pattern = 8'd249;
            4'd2: pattern = 8'd164;
            4'd3: pattern = 8'd176;
            4'd4: pattern = 8'd153;
            4'd5: pattern = 8'd146;
            4'd6: pattern = 8'd130;
            4'd7: pattern = 8'd248;
            4'd8: pattern = 8'd128;
            4'd9: pattern = 8'd144;
            default: pattern = SEG_BLANK;
        endcase
        return pattern;
    endfunction

    // split a value of at most 59 into tens and units by compares
    function automatic digit_pair_t split_digits(input logic [5:0] value);
        digit_pair_t pair;
        logic [5:0] base;
        if (value >= 6'd50) begin
            pair.tens = 4'd5;
            base = 6'd50;
        end else if (value >= 6'd40) begin
            pair.tens = 4'd4;
            base = 6'd40;
        end else if (value >= 6'd30) begin
            pair.tens = 4'd3;
            base = 6'd30;
        end else if (value >= 6'd20) begin
            pair.tens = 4'd2;
            base = 6'd20;
        end else if (value >= 6'd10) begin
            pair.tens = 4'd1;
            base = 6'd10;
        end else begin
            pair.tens = 4'd0;
            base = 6'd0;
        end
        pair.units = 4'(value - base);
        return pair;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/clock_with_seven_segment_scan.sv
`timescale 1ns / 1ps
`default_nettype none

// 24-hour clock with a four-digit multiplexed seven-segment scan. Each input word is an
// event in s_tuser (pulse, scan, clear, bump second/minute/hour, load) and gives exactly
// one result word carrying the latched active-low segment pattern, the one-hot (or all-off)
// digit enable and the time after that event. For each event the time, scan slot and
// display latches update in a single pass of logic into their registers at the accepting
// edge, and the result register beside them lets a new word in every cycle while the
// previous result is being taken, so throughput is one word per clock while m_tready is high.
// The result is registered and appears in the cycle after acceptance. The user must write
// settings through the cfg port while no event is in flight; the block does not enforce it.
module clock_with_seven_segment_scan (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // load_hours[4:0], load_minutes[10:5], load_seconds[16:11], zero fill
    input  wire logic [cssc_pkg::InDataWidth-1:0]      s_tdata,
    // kind[2:0]
    input  wire logic [cssc_pkg::KindWidth-1:0]        s_tuser,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // segment_drive[7:0], digit_enable[11:8], hours_now[16:12], minutes_now[22:17],
    // seconds_now[28:23], zero fill
    output logic [cssc_pkg::OutDataWidth-1:0]          m_tdata,
    input  wire logic                                  cfg_we,
    input  wire logic [cssc_pkg::CfgIndexWidth-1:0]    cfg_index,
    input  wire logic [cssc_pkg::CfgDataWidth-1:0]     cfg_data
);

    logic       run_enable_reg;
    logic       show_min_sec_reg;
    logic       display_enable_reg;
    logic [7:0] ticks_reg;

    logic [4:0] hour_reg,    hour_next;
    logic [5:0] minute_reg,  minute_next;
    logic [5:0] second_reg,  second_next;
    logic [7:0] sub_reg,     sub_next;
    logic [1:0] slot_reg,    slot_next;
    logic [7:0] seg_reg,     seg_next;
    logic [3:0] digit_reg,   digit_next;

    logic                                  m_valid_reg;
    logic [cssc_pkg::OutDataWidth-1:0]     m_data_reg;

    logic       accept;
    logic       digit_clear;
    logic [2:0] kind;
    logic [4:0] load_hours;
    logic [5:0] load_minutes;
    logic [5:0] load_seconds;
    logic [8:0] sub_inc;
    logic [5:0] first_value;
    logic [5:0] second_value;
    logic       dot_on;
    cssc_pkg::digit_pair_t first_pair;
    cssc_pkg::digit_pair_t second_pair;
    logic [7:0] scan_pattern;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // switching the display off blanks the digit drive at once
    assign digit_clear = cfg_we && (cfg_index == cssc_pkg::REG_DISPLAY_ENABLE) && !cfg_data[0];

    assign kind         = s_tuser;
    assign load_hours   = s_tdata[4:0];
    assign load_minutes = s_tdata[10:5];
    assign load_seconds = s_tdata[16:11];

    // digits always follow the current time and mode
    assign first_value  = show_min_sec_reg ? minute_reg : {1'b0, hour_reg};
    assign second_value = show_min_sec_reg ? second_reg : minute_reg;
    assign first_pair   = cssc_pkg::split_digits(first_value);
    assign second_pair  = cssc_pkg::split_digits(second_value);
    assign dot_on       = sub_reg < {1'b0, ticks_reg[7:1]};
    assign sub_inc      = {1'b0, sub_reg} + 9'd1;

    always_comb begin
        case (slot_reg)
            2'd3:    scan_pattern = cssc_pkg::seg_of(first_pair.tens);
            2'd2:    scan_pattern = dot_on
                         ? (cssc_pkg::seg_of(first_pair.units) & cssc_pkg::DOT_MASK)
                         : cssc_pkg::seg_of(first_pair.units);
            2'd1:    scan_pattern = cssc_pkg::seg_of(second_pair.tens);
            default: scan_pattern = cssc_pkg::seg_of(second_pair.units);
        endcase
    end

    always_comb begin
        hour_next   = hour_reg;
        minute_next = minute_reg;
        second_next = second_reg;
        sub_next    = sub_reg;
        slot_next   = slot_reg;
        seg_next    = seg_reg;
        digit_next  = digit_reg;
        unique case (kind)
            cssc_pkg::KIND_PULSE: begin
                if (run_enable_reg) begin
                    if (sub_inc >= {1'b0, ticks_reg}) begin
                        sub_next = '0;
                        // second tick with carries
                        if (second_reg < cssc_pkg::MAX_UNIT) begin
                            second_next = second_reg + 6'd1;
                        end else begin
                            second_next = '0;
                            if (minute_reg < cssc_pkg::MAX_UNIT) begin
                                minute_next = minute_reg + 6'd1;
                            end else begin
                                minute_next = '0;
                                hour_next = (hour_reg < cssc_pkg::MAX_HOUR)
                                    ? hour_reg + 5'd1 : 5'd0;
                            end
                        end
                    end else begin
                        sub_next = sub_inc[7:0];
                    end
                end
            end
            cssc_pkg::KIND_SCAN: begin
                if (display_enable_reg) begin
                    seg_next   = scan_pattern;
                    digit_next = 4'(1) << slot_reg;
                    slot_next  = slot_reg - 2'd1;
                end
            end
            cssc_pkg::KIND_CLEAR: begin
                hour_next   = '0;
                minute_next = '0;
                second_next = '0;
            end
            cssc_pkg::KIND_INC_SEC: begin
                second_next = (second_reg < cssc_pkg::MAX_UNIT) ? second_reg + 6'd1 : 6'd0;
            end
            cssc_pkg::KIND_INC_MIN: begin
                minute_next = (minute_reg < cssc_pkg::MAX_UNIT) ? minute_reg + 6'd1 : 6'd0;
            end
            cssc_pkg::KIND_INC_HOUR: begin
                hour_next = (hour_reg < cssc_pkg::MAX_HOUR) ? hour_reg + 5'd1 : 5'd0;
            end
            cssc_pkg::KIND_LOAD: begin
                hour_next   = (load_hours > cssc_pkg::MAX_HOUR) ? cssc_pkg::MAX_HOUR
                                                                 : load_hours;
                minute_next = (load_minutes > cssc_pkg::MAX_UNIT) ? cssc_pkg::MAX_UNIT
                                                                   : load_minutes;
                second_next = (load_seconds > cssc_pkg::MAX_UNIT) ? cssc_pkg::MAX_UNIT
                                                                   : load_seconds;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_enable_reg     <= 1'b0;
            show_min_sec_reg   <= 1'b0;
            display_enable_reg <= 1'b1;
            ticks_reg          <= cssc_pkg::TICKS_RESET;
            hour_reg           <= '0;
            minute_reg         <= '0;
            second_reg         <= '0;
            sub_reg            <= '0;
            slot_reg           <= cssc_pkg::SLOT_LEFT;
            seg_reg            <= cssc_pkg::SEG_BLANK;
            digit_reg          <= '0;
            m_valid_reg        <= 1'b0;
        end else begin
            if (accept) begin
                hour_reg    <= hour_next;
                minute_reg  <= minute_next;
                second_reg  <= second_next;
                sub_reg     <= sub_next;
                slot_reg    <= slot_next;
                seg_reg     <= seg_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (digit_clear) begin
                digit_reg <= '0;
            end else if (accept) begin
                digit_reg <= digit_next;
            end
            if (cfg_we) begin
                unique case (cfg_index)
                    cssc_pkg::REG_RUN_ENABLE:       run_enable_reg <= cfg_data[0];
                    cssc_pkg::REG_SHOW_MIN_SEC:     show_min_sec_reg <= cfg_data[0];
                    cssc_pkg::REG_DISPLAY_ENABLE:   display_enable_reg <= cfg_data[0];
                    cssc_pkg::REG_TICKS_PER_SECOND: ticks_reg <= cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // result word, payload needs no reset
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= {3'b000, second_next, minute_next, hour_next, digit_next, seg_next};
        end
    end

endmodule

`default_nettype wire
